>>> rtl/uv_sphere_vertex_generator_core_defines.svh
// Assertion macros used by the checker file of the sphere vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define UVS_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define UVS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/uvs_pkg.sv
// Package with types, constants and helper functions of the sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int ANG_W = 32;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic signed [CW-1:0] CORDIC_ONE = 34'sh040000000;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_RING = 2'd0;
	localparam logic [1:0] REG_SECTOR = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	// Arctangent table in binary-angle units.
	function automatic logic signed [CW-1:0] atan_turn(input int i);
		logic signed [CW-1:0] t;
		begin
			case (i)
				0: t = 34'sh020000000;
				1: t = 34'sh012E4051E;
				2: t = 34'sh009FB385B;
				3: t = 34'sh0051111D4;
				4: t = 34'sh0028B0D43;
				5: t = 34'sh00145D7E1;
				6: t = 34'sh000A2F61E;
				7: t = 34'sh000517C55;
				8: t = 34'sh00028BE53;
				9: t = 34'sh000145F2F;
				10: t = 34'sh0000A2F98;
				11: t = 34'sh0000517CC;
				12: t = 34'sh000028BE6;
				13: t = 34'sh0000145F3;
				14: t = 34'sh00000A2FA;
				15: t = 34'sh00000517D;
				16: t = 34'sh0000028BE;
				17: t = 34'sh00000145F;
				18: t = 34'sh000000A30;
				19: t = 34'sh000000518;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

	// Saturate to the signed 16-bit range.
	function automatic logic signed [15:0] sat16(input logic signed [CW:0] v);
		logic signed [15:0] r;
		begin
			if (v > 35'sd32767) begin
				r = 16'sh7FFF;
			end else if (v < -35'sd32768) begin
				r = 16'sh8000;
			end else begin
				r = v[15:0];
			end
			return r;
		end
	endfunction

	// Round a Q4.30 value to Q1.15 with ties up, then saturate.
	function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW:0] t;
		begin
			t = ($signed({v[CW-1], v}) + 35'sd16384) >>> 15;
			return sat16(t);
		end
	endfunction

	// State handed from one CORDIC cell to the next, for both angles.
	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] pz;
		logic signed [CW-1:0] tx;
		logic signed [CW-1:0] ty;
		logic signed [CW-1:0] tz;
		logic [1:0] pquad;
		logic [1:0] tquad;
		logic [15:0] radius;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [19:0] slot;
	} cell_data_t;

endpackage
`default_nettype wire

>>> rtl/uvs_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module uvs_divider #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 10,
	parameter int TAG_W = 8
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [NUM_W-1:0] num,
	input wire logic [DEN_W-1:0] den,
	input wire logic [TAG_W-1:0] tag_in,
	output logic [NUM_W-1:0] quot,
	output logic [TAG_W-1:0] tag_out
);

	logic [NUM_W-1:0] q_s [NUM_W+1];
	logic [DEN_W:0] rem_s [NUM_W+1];
	logic [DEN_W-1:0] den_s [NUM_W+1];
	logic [TAG_W-1:0] tag_s [NUM_W+1];

	assign q_s[0] = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;
	assign tag_s[0] = tag_in;

	// Each stage shifts in one numerator bit and tries a subtraction.
	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W+1:0] sh;
		logic [DEN_W+1:0] df;
		always_comb begin
			sh = {rem_s[i], q_s[i][NUM_W-1]};
			df = sh - {2'b00, den_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[DEN_W+1]) begin
					rem_s[i+1] <= df[DEN_W:0];
					q_s[i+1] <= {q_s[i][NUM_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= sh[DEN_W:0];
					q_s[i+1] <= {q_s[i][NUM_W-2:0], 1'b0};
				end
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign quot = q_s[NUM_W];
	assign tag_out = tag_s[NUM_W];

endmodule
`default_nettype wire

>>> rtl/uvs_cordic_cell.sv
// One CORDIC cell: a single micro-rotation for both angles, registered.
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic_cell #(
	parameter int STEP = 0
) (
	input wire logic clk,
	input wire logic en,
	input uvs_pkg::cell_data_t d_in,
	output uvs_pkg::cell_data_t d_out
);

	uvs_pkg::cell_data_t nx;
	localparam logic signed [uvs_pkg::CW-1:0] ATAN = uvs_pkg::atan_turn(STEP);

	// Rotate towards zero residual angle.
	always_comb begin
		nx = d_in;
		if (!d_in.pz[uvs_pkg::CW-1]) begin
			nx.px = d_in.px - (d_in.py >>> STEP);
			nx.py = d_in.py + (d_in.px >>> STEP);
			nx.pz = d_in.pz - ATAN;
		end else begin
			nx.px = d_in.px + (d_in.py >>> STEP);
			nx.py = d_in.py - (d_in.px >>> STEP);
			nx.pz = d_in.pz + ATAN;
		end
		if (!d_in.tz[uvs_pkg::CW-1]) begin
			nx.tx = d_in.tx - (d_in.ty >>> STEP);
			nx.ty = d_in.ty + (d_in.tx >>> STEP);
			nx.tz = d_in.tz - ATAN;
		end else begin
			nx.tx = d_in.tx + (d_in.ty >>> STEP);
			nx.ty = d_in.ty - (d_in.tx >>> STEP);
			nx.tz = d_in.tz + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nx;
		end
	end

endmodule
`default_nettype wire

>>> rtl/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator.
// Usage: an input request carries ring_index and sector_index on in_valid and
// leaves when in_stall is low. One result request per input leaves on out_valid
// with all vertex fields, taken when out_stall is low.
// Configuration: cfg_valid/cfg_ready write ring_count (0), sector_count (1) and
// sphere_radius (2) by cfg_index; cfg_ready is always high. Write only when idle.
// Throughput: one vertex per clock while no result is held by out_stall. A vertex
// passes stage 1, the bit-serial pipelined divider of the angles, the chain of
// CORDIC cells, and the registers of quadrant fold with rounding, products and output.
// The pipeline advances as a whole; when out_stall holds a valid result the
// whole pipe freezes and in_stall rises, so nothing is lost or repeated.
// Reset clears all valid flags and sets the registers to 10, 10 and 256.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_generator_core #(
	parameter int MAX_SUBDIV = 1023
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [9:0] ring_index,
	input wire logic [9:0] sector_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [23:0] pos_x,
	output logic signed [23:0] pos_y,
	output logic signed [23:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_z,
	output logic [16:0] tex_u,
	output logic [16:0] tex_v,
	output logic [19:0] vertex_slot,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);

	localparam int NUM_W = 43;
	localparam int DLY = 1 + NUM_W + uvs_pkg::CORDIC_STEPS + 3;
	localparam logic [9:0] MAXC = (MAX_SUBDIV > 1023) ? 10'd1023 : 10'(MAX_SUBDIV);

	logic [9:0] ring_cnt_q, sector_cnt_q;
	logic [15:0] radius_q;
	logic [DLY-1:0] vld_q;
	logic en;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_cnt_q <= 10'd10;
			sector_cnt_q <= 10'd10;
			radius_q <= 16'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uvs_pkg::REG_RING: ring_cnt_q <= cfg_data[9:0];
				uvs_pkg::REG_SECTOR: sector_cnt_q <= cfg_data[9:0];
				uvs_pkg::REG_RADIUS: radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipe moves unless a result is held at the output.
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DLY-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[DLY-1];

	// Stage 1: effective counts and clamped indices.
	logic [9:0] rings, sectors, r_c, s_c;
	logic [9:0] rings_s1, sectors_s1, r_s1, s_s1;
	logic [15:0] rad_s1;
	always_comb begin
		rings = (ring_cnt_q == 10'd0) ? 10'd1 : ((ring_cnt_q > MAXC) ? MAXC : ring_cnt_q);
		sectors = (sector_cnt_q == 10'd0) ? 10'd1 :
			((sector_cnt_q > MAXC) ? MAXC : sector_cnt_q);
		r_c = (ring_index > rings) ? rings : ring_index;
		s_c = (sector_index > sectors) ? sectors : sector_index;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rings_s1 <= rings;
			sectors_s1 <= sectors;
			r_s1 <= r_c;
			s_s1 <= s_c;
			rad_s1 <= radius_q;
		end
	end

	// Dividers for the two angles and the two texture coordinates; the radius,
	// the grid point and the sector count ride along as tags.
	logic [NUM_W-1:0] phi_num, th_num, u_num, v_num, phi_q, th_q, u_q, v_q;
	logic [15:0] rad_dv;
	logic [9:0] r_dv, s_dv, sec_dv;
	logic [19:0] slot_dv;
	always_comb begin
		phi_num = ({13'd0, r_s1, 20'd0} << 11) + NUM_W'(rings_s1 >> 1);
		th_num = ({23'd0, s_s1, 10'd0} << 22) + NUM_W'(sectors_s1 >> 1);
		u_num = NUM_W'({s_s1, 16'd0}) + NUM_W'(sectors_s1 >> 1);
		v_num = NUM_W'({r_s1, 16'd0}) + NUM_W'(rings_s1 >> 1);
	end
	uvs_divider #(.NUM_W(NUM_W), .DEN_W(10), .TAG_W(16)) u_div_phi (
		.clk(clk), .en(en), .num(phi_num), .den(rings_s1),
		.tag_in(rad_s1), .quot(phi_q), .tag_out(rad_dv));
	uvs_divider #(.NUM_W(NUM_W), .DEN_W(10), .TAG_W(10)) u_div_th (
		.clk(clk), .en(en), .num(th_num), .den(sectors_s1),
		.tag_in(r_s1), .quot(th_q), .tag_out(r_dv));
	uvs_divider #(.NUM_W(NUM_W), .DEN_W(10), .TAG_W(10)) u_div_u (
		.clk(clk), .en(en), .num(u_num), .den(sectors_s1),
		.tag_in(s_s1), .quot(u_q), .tag_out(s_dv));
	uvs_divider #(.NUM_W(NUM_W), .DEN_W(10), .TAG_W(10)) u_div_v (
		.clk(clk), .en(en), .num(v_num), .den(rings_s1),
		.tag_in(sectors_s1), .quot(v_q), .tag_out(sec_dv));

	// Linear vertex slot from the delayed grid point.
	assign slot_dv = 20'(r_dv * ({10'd0, sec_dv} + 20'd1)) + 20'(s_dv);

	// Seed the CORDIC chain; a zero residual bypasses with unity.
	uvs_pkg::cell_data_t chain [uvs_pkg::CORDIC_STEPS+1];
	logic [31:0] phi_a, th_a;
	logic p_zero_c, t_zero_c;
	logic [uvs_pkg::CORDIC_STEPS:0] pz_q, tz_q;
	always_comb begin
		phi_a = phi_q[31:0];
		th_a = th_q[31:0];
		p_zero_c = (phi_a[29:0] == 30'd0);
		t_zero_c = (th_a[29:0] == 30'd0);
		chain[0].px = uvs_pkg::CORDIC_GAIN;
		chain[0].py = '0;
		chain[0].pz = {4'd0, phi_a[29:0]};
		chain[0].tx = uvs_pkg::CORDIC_GAIN;
		chain[0].ty = '0;
		chain[0].tz = {4'd0, th_a[29:0]};
		chain[0].pquad = phi_a[31:30];
		chain[0].tquad = th_a[31:30];
		chain[0].radius = rad_dv;
		chain[0].tex_u = u_q[16:0];
		chain[0].tex_v = v_q[16:0];
		chain[0].slot = slot_dv;
	end
	assign pz_q[0] = p_zero_c;
	assign tz_q[0] = t_zero_c;

	for (genvar i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin : g_cell
		uvs_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en), .d_in(chain[i]), .d_out(chain[i+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				pz_q[i+1] <= pz_q[i];
				tz_q[i+1] <= tz_q[i];
			end
		end
	end

	// Quadrant fold and rounding to Q1.15.
	uvs_pkg::cell_data_t e;
	logic signed [uvs_pkg::CW-1:0] pxv, pyv, txv, tyv, pc, ps, tc, tsn;
	logic signed [15:0] cp_s2, sp_s2, ct_s2, st_s2;
	logic [15:0] rad_s2;
	logic [16:0] u_s2, v_s2;
	logic [19:0] slot_s2;
	always_comb begin
		e = chain[uvs_pkg::CORDIC_STEPS];
		pxv = pz_q[uvs_pkg::CORDIC_STEPS] ? uvs_pkg::CORDIC_ONE : e.px;
		pyv = pz_q[uvs_pkg::CORDIC_STEPS] ? '0 : e.py;
		txv = tz_q[uvs_pkg::CORDIC_STEPS] ? uvs_pkg::CORDIC_ONE : e.tx;
		tyv = tz_q[uvs_pkg::CORDIC_STEPS] ? '0 : e.ty;
		case (e.pquad)
			2'd0: begin pc = pxv; ps = pyv; end
			2'd1: begin pc = -pyv; ps = pxv; end
			2'd2: begin pc = -pxv; ps = -pyv; end
			default: begin pc = pyv; ps = -pxv; end
		endcase
		case (e.tquad)
			2'd0: begin tc = txv; tsn = tyv; end
			2'd1: begin tc = -tyv; tsn = txv; end
			2'd2: begin tc = -txv; tsn = -tyv; end
			default: begin tc = tyv; tsn = -txv; end
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cp_s2 <= uvs_pkg::to_q15(pc);
			sp_s2 <= uvs_pkg::to_q15(ps);
			ct_s2 <= uvs_pkg::to_q15(tc);
			st_s2 <= uvs_pkg::to_q15(tsn);
			rad_s2 <= e.radius;
			u_s2 <= e.tex_u;
			v_s2 <= e.tex_v;
			slot_s2 <= e.slot;
		end
	end

	// Normal products.
	logic signed [31:0] pnx, pnz;
	logic signed [15:0] nx_s3, ny_s3, nz_s3, tgx_s3, tgz_s3;
	logic [15:0] rad_s3;
	logic [16:0] u_s3, v_s3;
	logic [19:0] slot_s3;
	always_comb begin
		pnx = sp_s2 * ct_s2;
		pnz = sp_s2 * st_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= uvs_pkg::sat16(35'(($signed({{3{pnx[31]}}, pnx}) + 35'sd16384) >>> 15));
			nz_s3 <= uvs_pkg::sat16(35'(($signed({{3{pnz[31]}}, pnz}) + 35'sd16384) >>> 15));
			ny_s3 <= cp_s2;
			tgx_s3 <= uvs_pkg::sat16(-35'(st_s2));
			tgz_s3 <= ct_s2;
			rad_s3 <= rad_s2;
			u_s3 <= u_s2;
			v_s3 <= v_s2;
			slot_s3 <= slot_s2;
		end
	end

	// Positions: radius times normal, rounded from Q.23 to Q.15.
	logic signed [33:0] mx, my, mz;
	always_comb begin
		mx = $signed({1'b0, rad_s3}) * nx_s3;
		my = $signed({1'b0, rad_s3}) * ny_s3;
		mz = $signed({1'b0, rad_s3}) * nz_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= 24'((mx + 34'sd128) >>> 8);
			pos_y <= 24'((my + 34'sd128) >>> 8);
			pos_z <= 24'((mz + 34'sd128) >>> 8);
			norm_x <= nx_s3;
			norm_y <= ny_s3;
			norm_z <= nz_s3;
			tangent_x <= tgx_s3;
			tangent_z <= tgz_s3;
			tex_u <= u_s3;
			tex_v <= v_s3;
			vertex_slot <= slot_s3;
		end
	end

endmodule
`default_nettype wire

>>> rtl/uvs_checker.sv
// Port-level checker for the sphere vertex generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "uv_sphere_vertex_generator_core_defines.svh"
module uvs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic cfg_ready,
	input wire logic [19:0] vertex_slot,
	input wire logic [16:0] tex_u
);

	`UVS_ASSERT_IMPL(a_stall_tracks_out, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a held result")
	`UVS_ASSERT_NEXT(a_hold_slot, clk, arst_n, out_valid && out_stall, $stable(vertex_slot) && $stable(tex_u), "held result changed")
	`UVS_ASSERT_IMPL(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration port not ready")
	`UVS_ASSERT_IMPL(a_u_range, clk, arst_n, out_valid, tex_u <= 17'd65536, "u out of range")

endmodule

bind uv_sphere_vertex_generator_core uvs_checker u_uvs_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .cfg_ready(cfg_ready), .vertex_slot(vertex_slot), .tex_u(tex_u));
`default_nettype wire
